>>> rtl/pfe_pkg.sv
// palette fade engine package: sizes, operation and fade codes, sequencer states
// and the per-entry color step shared by the tick walk; no dependencies
package pfe_pkg;

  localparam int unsigned BankEntries = 64;
  localparam int unsigned IdxW        = $clog2(BankEntries);
  localparam int unsigned AddrW       = IdxW + 2;
  localparam int unsigned Depth       = 4 * BankEntries;
  localparam int unsigned WalkW       = ((IdxW > 6) ? IdxW : 6) + 1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [2:0] KIND_IDLE      = 3'd0;
  localparam logic [2:0] KIND_FADE_IN   = 3'd1;
  localparam logic [2:0] KIND_FADE_OUT  = 3'd2;
  localparam logic [2:0] KIND_FLASH_IN  = 3'd3;
  localparam logic [2:0] KIND_FLASH_OUT = 3'd4;

  localparam logic [1:0] BANK_CUR_A = 2'd0;

  localparam logic [1:0] CFG_FIRST_ENTRY = 2'd0;
  localparam logic [1:0] CFG_LAST_OFFSET = 2'd1;
  localparam logic [1:0] CFG_SKIP_BANK_B = 2'd2;

  localparam logic [7:0] STEP      = 8'd32;
  localparam logic [7:0] BRIGHT    = 8'd224;
  localparam logic [4:0] LAST_TICK = 5'd21;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] bank;
    logic [5:0] index;
    rgb_t       rgb;
    logic [2:0] fade_kind;
  } pfe_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_CLEAR,
    ST_TICK,
    ST_DONE
  } pfe_state_e;

  // one fade step on one entry, rgb packed as red, green, blue from the top
  function automatic rgb_t step_entry(logic [2:0] kind, rgb_t cur, rgb_t tgt);
    logic [7:0] cr, cg, cb, tr, tg, tb;
    rgb_t       res;
    cr  = cur[23:16];
    cg  = cur[15:8];
    cb  = cur[7:0];
    tr  = tgt[23:16];
    tg  = tgt[15:8];
    tb  = tgt[7:0];
    res = cur;
    case (kind)
      KIND_FADE_IN: begin
        if (tb > cb) res[7:0] = cb + STEP;
        else if (tg > cg) res[15:8] = cg + STEP;
        else if (tr > cr) res[23:16] = cr + STEP;
      end
      KIND_FLASH_IN: begin
        if (tb < cb) res[7:0] = cb - STEP;
        else if (tg < cg) res[15:8] = cg - STEP;
        else if (tr < cr) res[23:16] = cr - STEP;
      end
      KIND_FADE_OUT: begin
        if (cr != 8'd0) res[23:16] = cr - STEP;
        else if (cg != 8'd0) res[15:8] = cg - STEP;
        else if (cb != 8'd0) res[7:0] = cb - STEP;
      end
      KIND_FLASH_OUT: begin
        if (cr != BRIGHT) res[23:16] = cr + STEP;
        else if (cg != BRIGHT) res[15:8] = cg + STEP;
        else if (cb != BRIGHT) res[7:0] = cb + STEP;
      end
      default: res = cur;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/pfe_if.sv
// palette fade engine channel interfaces: operation beats in, result beats out,
// configuration writes; no dependencies
interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [1:0] bank;
  logic [5:0] index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [2:0] fade_kind;

  modport source (output valid, operation, bank, index, red_in, green_in, blue_in,
                  fade_kind, input ready);
  modport sink (input valid, operation, bank, index, red_in, green_in, blue_in,
                fade_kind, output ready);
endinterface

interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       fade_done;
  logic [2:0] active_kind;

  modport source (output valid, red_out, green_out, blue_out, fade_done, active_kind,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, fade_done, active_kind,
                output ready);
endinterface

interface pfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/palette_fade_engine_core.sv
// palette fade engine top level: palette memory, sequencer and shared step unit
// depends on pfe_pkg and the channel interfaces in pfe_if.sv
//
// Takes one operation beat at a time and returns one result beat for it. The palette
// is a single memory of four banks (current A, target A, current B, target B) with one
// write port and two registered read ports. Fade-in and flash-in starts sweep bank
// current A one entry a cycle over their range. A frame tick of a running fade streams
// one entry a cycle through the step unit, reading current and target together and
// writing back in the cycle after, over the range once per bank pair, for one or two
// pairs. A result beat that is not taken lets one more beat in; that beat waits with
// its result finished and the input stalls until the output frees.
module palette_fade_engine_core
  import pfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pfe_in_if.sink    in_i,
  pfe_out_if.source out_o,
  pfe_cfg_if.sink   cfg_i
);

  pfe_state_e state_q, state_d;
  pfe_item_t  item_q;

  logic [5:0]       first_q, offset_q;
  logic             skip_q;
  logic [2:0]       mode_q, mode_d;
  logic [4:0]       tick_q, tick_d;
  logic [WalkW-1:0] rfirst_q, rfirst_d, rlast_q, rlast_d, walk_q, walk_d;
  logic             pair_q, pair_d, issue_q, issue_d, p1_valid_q, p1_valid_d;
  logic [AddrW-1:0] p1_addr_q, p1_addr_d;
  rgb_t             res_rgb_q, res_rgb_d;
  logic             res_done_q, res_done_d;

  logic             out_valid_q;
  rgb_t             out_rgb_q;
  logic             out_done_q;
  logic [2:0]       out_kind_q;
  logic             load_out;

  rgb_t             mem [Depth];
  rgb_t             rd_a_q, rd_b_q;
  logic [AddrW-1:0] rd_a_addr, rd_b_addr, wa;
  logic             we;
  rgb_t             wd;

  logic [WalkW-1:0] idx_ext, last_sum;
  logic             idx_ok, second_pair;
  logic [AddrW-1:0] item_addr;

  assign idx_ext     = WalkW'(item_q.index);
  assign idx_ok      = idx_ext < WalkW'(BankEntries);
  assign item_addr   = {item_q.bank, idx_ext[IdxW-1:0]};
  assign last_sum    = WalkW'(first_q) + WalkW'(offset_q);
  assign second_pair = (mode_q == KIND_FADE_OUT) || (mode_q == KIND_FLASH_OUT) || !skip_q;

  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.red_out     = out_rgb_q[23:16];
  assign out_o.green_out   = out_rgb_q[15:8];
  assign out_o.blue_out    = out_rgb_q[7:0];
  assign out_o.fade_done   = out_done_q;
  assign out_o.active_kind = out_kind_q;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    tick_d     = tick_q;
    rfirst_d   = rfirst_q;
    rlast_d    = rlast_q;
    walk_d     = walk_q;
    pair_d     = pair_q;
    issue_d    = issue_q;
    p1_valid_d = p1_valid_q;
    p1_addr_d  = p1_addr_q;
    res_rgb_d  = res_rgb_q;
    res_done_d = res_done_q;
    rd_a_addr  = item_addr;
    rd_b_addr  = item_addr;
    we         = 1'b0;
    wa         = item_addr;
    wd         = item_q.rgb;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        res_rgb_d  = '0;
        res_done_d = 1'b0;
        state_d    = ST_DONE;
        case (item_q.operation)
          OP_WRITE: begin
            we = idx_ok;
          end
          OP_READ: begin
            state_d = ST_RDWAIT;
          end
          OP_START: begin
            case (item_q.fade_kind)
              KIND_IDLE: begin
                mode_d = KIND_IDLE;
                tick_d = '0;
              end
              KIND_FADE_IN: begin
                rfirst_d = WalkW'(first_q);
                rlast_d  = (last_sum > WalkW'(BankEntries - 1)) ?
                           WalkW'(BankEntries - 1) : last_sum;
                walk_d   = WalkW'(first_q);
                mode_d   = item_q.fade_kind;
                tick_d   = '0;
                state_d  = ST_CLEAR;
              end
              KIND_FLASH_IN: begin
                rfirst_d = '0;
                rlast_d  = WalkW'(BankEntries - 1);
                walk_d   = '0;
                mode_d   = item_q.fade_kind;
                tick_d   = '0;
                state_d  = ST_CLEAR;
              end
              KIND_FADE_OUT, KIND_FLASH_OUT: begin
                rfirst_d = '0;
                rlast_d  = WalkW'(BankEntries - 1);
                mode_d   = item_q.fade_kind;
                tick_d   = '0;
              end
              default: state_d = ST_DONE;
            endcase
          end
          OP_TICK: begin
            if (mode_q == KIND_IDLE) begin
              res_done_d = 1'b1;
            end else begin
              walk_d     = rfirst_q;
              pair_d     = 1'b0;
              issue_d    = 1'b1;
              p1_valid_d = 1'b0;
              state_d    = ST_TICK;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_RDWAIT: begin
        res_rgb_d = idx_ok ? rd_a_q : '0;
        state_d   = ST_DONE;
      end
      ST_CLEAR: begin
        if (walk_q > rlast_q) begin
          state_d = ST_DONE;
        end else begin
          we     = 1'b1;
          wa     = {BANK_CUR_A, walk_q[IdxW-1:0]};
          wd     = (mode_q == KIND_FLASH_IN) ? {BRIGHT, BRIGHT, BRIGHT} : '0;
          walk_d = walk_q + WalkW'(1);
        end
      end
      ST_TICK: begin
        p1_valid_d = 1'b0;
        if (p1_valid_q) begin
          we = 1'b1;
          wa = p1_addr_q;
          wd = step_entry(mode_q, rd_a_q, rd_b_q);
        end
        if (issue_q) begin
          if (walk_q > rlast_q) begin
            if (!pair_q && second_pair) begin
              pair_d = 1'b1;
              walk_d = rfirst_q;
            end else begin
              issue_d = 1'b0;
            end
          end else begin
            rd_a_addr  = {pair_q, 1'b0, walk_q[IdxW-1:0]};
            rd_b_addr  = {pair_q, 1'b1, walk_q[IdxW-1:0]};
            p1_valid_d = 1'b1;
            p1_addr_d  = {pair_q, 1'b0, walk_q[IdxW-1:0]};
            walk_d     = walk_q + WalkW'(1);
          end
        end else if (!p1_valid_q) begin
          if (tick_q == LAST_TICK) begin
            tick_d     = '0;
            mode_d     = KIND_IDLE;
            res_done_d = 1'b1;
          end else begin
            tick_d = tick_q + 5'd1;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= KIND_IDLE;
      tick_q      <= '0;
      rfirst_q    <= '0;
      rlast_q     <= WalkW'(BankEntries - 1);
      walk_q      <= '0;
      pair_q      <= 1'b0;
      issue_q     <= 1'b0;
      p1_valid_q  <= 1'b0;
      first_q     <= '0;
      offset_q    <= 6'd63;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      tick_q     <= tick_d;
      rfirst_q   <= rfirst_d;
      rlast_q    <= rlast_d;
      walk_q     <= walk_d;
      pair_q     <= pair_d;
      issue_q    <= issue_d;
      p1_valid_q <= p1_valid_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_FIRST_ENTRY: first_q  <= cfg_i.data[5:0];
          CFG_LAST_OFFSET: offset_q <= cfg_i.data[5:0];
          CFG_SKIP_BANK_B: skip_q   <= cfg_i.data[0];
          default:         skip_q   <= skip_q;
        endcase
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // payload registers and palette memory
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.operation <= in_i.operation;
      item_q.bank      <= in_i.bank;
      item_q.index     <= in_i.index;
      item_q.rgb       <= {in_i.red_in, in_i.green_in, in_i.blue_in};
      item_q.fade_kind <= in_i.fade_kind;
    end
    p1_addr_q  <= p1_addr_d;
    res_rgb_q  <= res_rgb_d;
    res_done_q <= res_done_d;
    if (load_out) begin
      out_rgb_q  <= res_rgb_q;
      out_done_q <= res_done_q;
      out_kind_q <= mode_q;
    end
    if (we) mem[wa] <= wd;
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

`ifndef ASSERT_OFF
  a_idle_no_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == KIND_IDLE) |-> (tick_q == '0))
    else $error("tick count left over while idle");

  a_tick_writes_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && (state_q == ST_TICK || state_q == ST_CLEAR)) |-> !wa[IdxW])
    else $error("fade wrote a target bank");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result beat without a finished item");

  a_stream_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK && state_d == ST_DONE) |-> (!issue_q && !p1_valid_q))
    else $error("tick finished with entries in flight");
`endif

endmodule

>>> dv/testbench.sv
// palette fade engine testbench: sends operation beats and register writes,
// predicts each result beat and checks it field by field
// depends on pfe_pkg, the channel interfaces in pfe_if.sv and palette_fade_engine_core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  localparam logic [1:0] BANK_TGT_A  = 2'd1;
  localparam logic [1:0] BANK_CUR_B  = 2'd2;
  localparam logic [1:0] BANK_TGT_B  = 2'd3;
  localparam logic [2:0] KIND_BAD_LO = 3'd5;
  localparam logic [2:0] KIND_BAD_HI = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       done;
    logic [2:0] kind;
  } fade_result_t;

  typedef struct {
    pfe_item_t    op;
    int unsigned  reps;
    bit           typed;
    fade_result_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  pfe_in_if  op_if ();
  pfe_out_if res_if ();
  pfe_cfg_if cfg_if ();

  palette_fade_engine_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  // shadow palette and fade state
  rgb_t       palette [4][BankEntries];
  logic [2:0] fade_mode;
  logic [4:0] tick_count;
  int         range_lo;
  int         range_hi;
  logic [5:0] cfg_first;
  logic [5:0] cfg_offset;
  logic       cfg_skip;

  fade_result_t expected_results [$];
  stim_row_t    directed_rows [$];
  int unsigned  mismatches = 0;
  int unsigned  sender_idle_pct = 38;
  int unsigned  sink_idle_pct = 59;
  int unsigned  sink_hold = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // blue first, then green, then red
  function automatic rgb_t chase_target(rgb_t cur, rgb_t tgt, bit up);
    rgb_t       res;
    logic [7:0] c;
    logic [7:0] t;
    bit         moved;
    res   = cur;
    moved = 1'b0;
    for (int k = 0; k < 3; k++) begin
      c = cur[8*k +: 8];
      t = tgt[8*k +: 8];
      if (!moved && (up ? (t > c) : (t < c))) begin
        res[8*k +: 8] = up ? c + STEP : c - STEP;
        moved = 1'b1;
      end
    end
    return res;
  endfunction

  // red first, then green, then blue
  function automatic rgb_t chase_level(rgb_t cur, bit to_black);
    rgb_t       res;
    logic [7:0] c;
    bit         moved;
    res   = cur;
    moved = 1'b0;
    for (int k = 2; k >= 0; k--) begin
      c = cur[8*k +: 8];
      if (!moved && (to_black ? (c != 8'd0) : (c != BRIGHT))) begin
        res[8*k +: 8] = to_black ? c - STEP : c + STEP;
        moved = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic fade_result_t apply_palette_op(pfe_item_t it);
    fade_result_t r;
    int           last;
    r = '0;
    case (it.operation)
      OP_WRITE: palette[it.bank][it.index] = it.rgb;
      OP_READ: {r.red, r.green, r.blue} = palette[it.bank][it.index];
      OP_START: begin
        if (it.fade_kind == KIND_IDLE) begin
          fade_mode  = KIND_IDLE;
          tick_count = '0;
        end else if (it.fade_kind <= KIND_FLASH_OUT) begin
          if (it.fade_kind == KIND_FADE_IN) begin
            last     = cfg_first + cfg_offset;
            range_lo = cfg_first;
            range_hi = (last > BankEntries - 1) ? BankEntries - 1 : last;
            for (int i = range_lo; i <= range_hi; i++) palette[BANK_CUR_A][i] = '0;
          end else begin
            range_lo = 0;
            range_hi = BankEntries - 1;
            if (it.fade_kind == KIND_FLASH_IN) begin
              for (int i = 0; i < BankEntries; i++) palette[BANK_CUR_A][i] = {3{BRIGHT}};
            end
          end
          fade_mode  = it.fade_kind;
          tick_count = '0;
        end
      end
      OP_TICK: begin
        if (fade_mode == KIND_IDLE) begin
          r.done = 1'b1;
        end else begin
          for (int i = range_lo; i <= range_hi; i++) begin
            if (fade_mode == KIND_FADE_IN || fade_mode == KIND_FLASH_IN) begin
              palette[BANK_CUR_A][i] = chase_target(palette[BANK_CUR_A][i],
                                                    palette[BANK_TGT_A][i],
                                                    fade_mode == KIND_FADE_IN);
              if (!cfg_skip) begin
                palette[BANK_CUR_B][i] = chase_target(palette[BANK_CUR_B][i],
                                                      palette[BANK_TGT_B][i],
                                                      fade_mode == KIND_FADE_IN);
              end
            end else begin
              palette[BANK_CUR_A][i] = chase_level(palette[BANK_CUR_A][i],
                                                   fade_mode == KIND_FADE_OUT);
              palette[BANK_CUR_B][i] = chase_level(palette[BANK_CUR_B][i],
                                                   fade_mode == KIND_FADE_OUT);
            end
          end
          tick_count++;
          if (tick_count > LAST_TICK) begin
            tick_count = '0;
            fade_mode  = KIND_IDLE;
            r.done     = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.kind = fade_mode;
    return r;
  endfunction

  function automatic pfe_item_t beat(logic [1:0] op, logic [1:0] bank, logic [5:0] index,
                                     rgb_t rgb, logic [2:0] kind);
    pfe_item_t it;
    it.operation = op;
    it.bank      = bank;
    it.index     = index;
    it.rgb       = rgb;
    it.fade_kind = kind;
    return it;
  endfunction

  function automatic pfe_item_t any_beat(logic [1:0] op);
    return beat(op, 2'($urandom_range(3)), 6'($urandom_range(63)), 24'($urandom),
                3'($urandom_range(7)));
  endfunction

  function automatic fade_result_t outcome(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic done, logic [2:0] kind);
    fade_result_t res;
    res.red   = r;
    res.green = g;
    res.blue  = b;
    res.done  = done;
    res.kind  = kind;
    return res;
  endfunction

  function automatic void add_row(pfe_item_t op, int unsigned reps, bit typed,
                                  fade_result_t want);
    stim_row_t row;
    row.op    = op;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic offer(pfe_item_t it, bit typed = 1'b0, fade_result_t want = '0);
    fade_result_t got;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      op_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    op_if.valid     <= 1'b1;
    op_if.operation <= it.operation;
    op_if.bank      <= it.bank;
    op_if.index     <= it.index;
    op_if.red_in    <= it.rgb[23:16];
    op_if.green_in  <= it.rgb[15:8];
    op_if.blue_in   <= it.rgb[7:0];
    op_if.fade_kind <= it.fade_kind;
    do @(posedge clk_i); while (!op_if.ready);
    got = apply_palette_op(it);
    expected_results.push_back(typed ? want : got);
  endtask

  task automatic wait_results_drained();
    op_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic write_register(logic [1:0] idx, logic [7:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_FIRST_ENTRY: cfg_first = data[5:0];
      CFG_LAST_OFFSET: cfg_offset = data[5:0];
      default: cfg_skip = data[0];
    endcase
  endtask

  task automatic program_fade_range(logic [5:0] first, logic [5:0] offset, logic skip);
    logic [7:0] noise;
    noise = 8'($urandom);
    write_register(CFG_FIRST_ENTRY, {noise[7:6], first});
    write_register(CFG_LAST_OFFSET, {noise[5:4], offset});
    write_register(CFG_SKIP_BANK_B, {noise[7:1], skip});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned budget, bit long_hold, bit mid_pause);
    pfe_item_t   it;
    int unsigned sent;
    int unsigned ticks;
    bit          pressed;
    sent    = 0;
    pressed = 1'b0;
    while (sent < budget) begin
      if (!pressed && sent >= budget / 2) begin
        pressed = 1'b1;
        if (long_hold) sink_hold = 300;
        if (mid_pause) wait_results_drained();
      end
      if ($urandom_range(9) == 0) begin
        it = any_beat(2'($urandom_range(3)));
        offer(it);
        if (!(it.operation == OP_START && it.fade_kind > KIND_FLASH_OUT)) sent++;
      end else begin
        repeat ($urandom_range(3)) begin
          offer(any_beat(OP_WRITE));
          sent++;
        end
        offer(beat(OP_START, 2'($urandom_range(3)), 6'($urandom_range(63)), 24'($urandom),
                   3'($urandom_range(KIND_FLASH_OUT, KIND_FADE_IN))));
        sent++;
        // short runs leave the fade going so the next start lands on a running one
        ticks = ($urandom_range(3) == 0) ? $urandom_range(21, 1) : 22;
        repeat (ticks) begin
          if ($urandom_range(2) == 0) begin
            offer(any_beat($urandom_range(1) ? OP_READ : OP_WRITE));
            sent++;
          end
          offer(any_beat(OP_TICK));
          sent++;
        end
      end
    end
  endtask

  initial begin : result_sink
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold != 0) begin
        res_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    fade_result_t want;
    if (res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat red %0d green %0d blue %0d done %0d kind %0d",
                 $time, res_if.red_out, res_if.green_out, res_if.blue_out,
                 res_if.fade_done, res_if.active_kind);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("red_out", want.red, res_if.red_out);
        check_field("green_out", want.green, res_if.green_out);
        check_field("blue_out", want.blue, res_if.blue_out);
        check_field("fade_done", want.done, res_if.fade_done);
        check_field("active_kind", want.kind, res_if.active_kind);
      end
    end
  end

  initial begin : stimulus
    rst_ni          <= 1'b0;
    op_if.valid     <= 1'b0;
    op_if.operation <= OP_WRITE;
    op_if.bank      <= BANK_CUR_A;
    op_if.index     <= '0;
    op_if.red_in    <= '0;
    op_if.green_in  <= '0;
    op_if.blue_in   <= '0;
    op_if.fade_kind <= KIND_IDLE;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_FIRST_ENTRY;
    cfg_if.data     <= '0;
    fade_mode  = KIND_IDLE;
    tick_count = '0;
    range_lo   = 0;
    range_hi   = BankEntries - 1;
    cfg_first  = '0;
    cfg_offset = 6'd63;
    cfg_skip   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    program_fade_range(6'd0, 6'd63, 1'b0);

    // every entry of every bank gets written before anything reads or fades it
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < BankEntries; i++) begin
        offer(beat(OP_WRITE, 2'(b), 6'(i), 24'($urandom), 3'($urandom)));
      end
    end

    add_row(beat(OP_TICK, 0, 0, '0, 0), 1, 1, outcome(0, 0, 0, 1, KIND_IDLE));
    add_row(beat(OP_START, 0, 0, '0, KIND_IDLE), 1, 1, outcome(0, 0, 0, 0, KIND_IDLE));
    add_row(beat(OP_START, 0, 0, '0, KIND_BAD_LO), 1, 1, outcome(0, 0, 0, 0, KIND_IDLE));
    add_row(beat(OP_START, 3, 63, '1, KIND_BAD_HI), 1, 1, outcome(0, 0, 0, 0, KIND_IDLE));
    add_row(beat(OP_WRITE, BANK_TGT_A, 63, 24'hffffff, 0), 1, 1,
            outcome(0, 0, 0, 0, KIND_IDLE));
    add_row(beat(OP_READ, BANK_TGT_A, 63, '0, 0), 1, 1,
            outcome(8'hff, 8'hff, 8'hff, 0, KIND_IDLE));
    add_row(beat(OP_WRITE, BANK_TGT_B, 0, 24'h000000, 0), 1, 1,
            outcome(0, 0, 0, 0, KIND_IDLE));
    add_row(beat(OP_READ, BANK_TGT_B, 0, '0, 0), 1, 1, outcome(0, 0, 0, 0, KIND_IDLE));
    add_row(beat(OP_WRITE, BANK_CUR_B, 63, 24'h8040ff, 0), 1, 1,
            outcome(0, 0, 0, 0, KIND_IDLE));
    add_row(beat(OP_READ, BANK_CUR_B, 63, '0, 0), 1, 1,
            outcome(8'h80, 8'h40, 8'hff, 0, KIND_IDLE));
    add_row(beat(OP_START, 0, 0, '0, KIND_FADE_IN), 1, 1, outcome(0, 0, 0, 0, KIND_FADE_IN));
    add_row(beat(OP_READ, BANK_CUR_A, 63, '0, 0), 1, 1, outcome(0, 0, 0, 0, KIND_FADE_IN));
    add_row(beat(OP_TICK, 0, 0, '0, 0), 1, 1, outcome(0, 0, 0, 0, KIND_FADE_IN));
    add_row(beat(OP_READ, BANK_CUR_A, 63, '0, 0), 1, 1, outcome(0, 0, 32, 0, KIND_FADE_IN));
    add_row(beat(OP_READ, BANK_CUR_B, 63, '0, 0), 1, 0, '0);
    add_row(beat(OP_START, 0, 0, '0, KIND_FLASH_IN), 1, 1, outcome(0, 0, 0, 0, KIND_FLASH_IN));
    add_row(beat(OP_READ, BANK_CUR_A, 31, '0, 0), 1, 1,
            outcome(BRIGHT, BRIGHT, BRIGHT, 0, KIND_FLASH_IN));
    add_row(beat(OP_TICK, 0, 0, '0, 0), 3, 0, '0);
    add_row(beat(OP_START, 0, 0, '0, KIND_FADE_OUT), 1, 1, outcome(0, 0, 0, 0, KIND_FADE_OUT));
    add_row(beat(OP_TICK, 0, 0, '0, 0), 21, 0, '0);
    add_row(beat(OP_TICK, 0, 0, '0, 0), 1, 1, outcome(0, 0, 0, 1, KIND_IDLE));
    add_row(beat(OP_TICK, 0, 0, '0, 0), 1, 1, outcome(0, 0, 0, 1, KIND_IDLE));
    add_row(beat(OP_START, 0, 0, '0, KIND_FLASH_OUT), 1, 1,
            outcome(0, 0, 0, 0, KIND_FLASH_OUT));
    add_row(beat(OP_TICK, 0, 0, '0, 0), 5, 0, '0);
    add_row(beat(OP_READ, BANK_CUR_B, 63, '0, 0), 1, 0, '0);
    add_row(beat(OP_START, 0, 0, '0, KIND_IDLE), 1, 1, outcome(0, 0, 0, 0, KIND_IDLE));

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps) begin
        offer(directed_rows[r].op, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    run_random(30, 1'b1, 1'b0);
    wait_results_drained();

    sender_idle_pct = 59;
    sink_idle_pct   = 38;
    program_fade_range(6'd63, 6'd0, 1'b1);
    run_random(30, 1'b0, 1'b1);
    wait_results_drained();

    sender_idle_pct = 0;
    sink_idle_pct   = 0;
    program_fade_range(6'd21, 6'd50, 1'b0);
    run_random(15, 1'b0, 1'b0);
    wait_results_drained();

    program_fade_range(6'd5, 6'd9, 1'b1);
    run_random(15, 1'b0, 1'b0);
    wait_results_drained();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
